/* src/smac_pkg.sv */
// Shared types, constants and a helper function for the stochastic Mealy automaton.
package smac_pkg;

    // Default sizes of the tables and the weight total
    localparam int MAX_STATES_DEF   = 16;
    localparam int MAX_SYMBOLS_DEF  = 16;
    localparam int MAX_ACTIONS_DEF  = 16;
    localparam int WEIGHT_TOTAL_DEF = 256;

    // Field widths
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int RND_W    = 12;
    localparam int WEIGHT_W = 8;
    localparam int CNT_W    = 9;   // compare width for effective counts
    localparam int SUM_W    = 13;  // holds a sum of up to 32 weights of 8 bits
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W   = 37;  // 12-bit value times 25-bit reciprocal

    // Request codes
    localparam logic [1:0] REQ_WR_NEXT   = 2'd0;
    localparam logic [1:0] REQ_WR_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_STEP      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIONS = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Input transaction
    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  state_index;
        logic [3:0]  symbol_in;
        logic [3:0]  action_index;
        logic [7:0]  table_value;
        logic [11:0] random_value;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic [3:0] action_out;
        logic [3:0] state_after;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic decode;
        logic write;
        logic lookup;
        logic reduce;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_write;
        logic step_ok;
        logic scan_hit;
    } dp_status_t;

    // Effective count: zero acts as one, values above the maximum saturate
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input int maxv);
        if (v == '0)
            return CNT_W'(1);
        else if (int'(v) > maxv)
            return CNT_W'(maxv);
        else
            return CNT_W'(v);
    endfunction

endpackage

/* src/smac_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/smac_ctrl.sv */
// Sequencing state machine for the stochastic Mealy automaton.
module smac_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  smac_pkg::dp_status_t   status,
    output smac_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_WRITE  = 7'b0000100,
        ST_LOOKUP = 7'b0001000,
        ST_REDUCE = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Output register can take a result when empty or being drained
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (status.is_write)
                    state_next = ST_WRITE;
                else if (status.step_ok)
                    state_next = ST_LOOKUP;
                else
                    state_next = ST_DONE;
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_DONE;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_hit)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // A result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && rsp_stall))
        else $error("result register overwritten");

    // The scan ends in the result state once a weight hits
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_hit) |=> (state_reg == ST_DONE))
        else $error("scan did not finish on hit");

    // Every accepted transaction is decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");
`endif

endmodule

/* src/smac_dp.sv */
// Datapath: configuration, tables, threshold reduction and weight scan.
module smac_dp #(
    parameter int MAX_STATES   = smac_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS  = smac_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_ACTIONS  = smac_pkg::MAX_ACTIONS_DEF,
    parameter int WEIGHT_TOTAL = smac_pkg::WEIGHT_TOTAL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [smac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smac_pkg::CFG_W-1:0]        cfg_data,
    input  smac_pkg::in_item_t                req,
    output smac_pkg::out_item_t               rsp,
    input  smac_pkg::ctrl_cmd_t               cmd,
    output smac_pkg::dp_status_t              status
);

    localparam int SW       = $clog2(MAX_STATES);
    localparam int NS_DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int RW       = $clog2(NS_DEPTH);
    localparam int WT_DEPTH = NS_DEPTH * MAX_ACTIONS;
    localparam int WAW      = $clog2(WT_DEPTH);
    localparam int AXW      = $clog2(MAX_ACTIONS);
    localparam int CW       = smac_pkg::CNT_W;
    localparam int PW       = smac_pkg::PROD_W;
    localparam int RECIP    = ((1 << smac_pkg::RECIP_SHIFT) + WEIGHT_TOTAL - 1) / WEIGHT_TOTAL;

    // Configuration registers
    logic [smac_pkg::CFG_W-1:0] ns_cfg_reg;
    logic [smac_pkg::CFG_W-1:0] nx_cfg_reg;
    logic [smac_pkg::CFG_W-1:0] na_cfg_reg;

    // Transaction and working registers
    smac_pkg::in_item_t         item_reg;
    logic [SW-1:0]              cs_reg;
    logic [RW-1:0]              row_reg;
    logic [WAW-1:0]             base_reg;
    logic [PW-1:0]              prod_reg;
    logic [11:0]                qd_reg;
    logic [11:0]                p_reg;
    logic [SW-1:0]              nxt_reg;
    logic [AXW-1:0]             cnt_reg;
    logic [smac_pkg::SUM_W-1:0] sum_reg;
    logic [AXW-1:0]             act_reg;
    smac_pkg::out_item_t        out_reg;

    // Combinational signals
    logic [CW-1:0]              ns_eff;
    logic [CW-1:0]              nx_eff;
    logic [CW-1:0]              na_eff;
    logic [CW-1:0]              na_last;
    logic                       st_ok;
    logic                       sym_ok;
    logic                       act_ok;
    logic                       val_ok;
    logic                       cs_ok;
    logic                       is_step;
    logic [7:0]                 sel_state;
    logic [RW+8:0]              row_full;
    logic [WAW+8:0]             base_full;
    logic [WAW-1:0]             wt_waddr;
    logic [WAW-1:0]             wt_raddr;
    logic [WAW-1:0]             cnt_plus;
    logic                       ns_we;
    logic                       wt_we;
    logic                       wt_re;
    logic [SW-1:0]              ns_rdata;
    logic [smac_pkg::WEIGHT_W-1:0] wt_rdata;
    logic [PW-1:0]              prod_next;
    logic [12:0]                quot;
    logic [24:0]                qd_full;
    logic [11:0]                p_raw;
    logic [11:0]                p_next;
    logic [smac_pkg::SUM_W-1:0] sum_next;
    logic                       scan_hit;
    logic [AXW+3:0]             act_ext;
    logic [SW+3:0]              cs_ext;

    // Effective sizes
    assign ns_eff  = smac_pkg::clamp_count(ns_cfg_reg, MAX_STATES);
    assign nx_eff  = smac_pkg::clamp_count(nx_cfg_reg, MAX_SYMBOLS);
    assign na_eff  = smac_pkg::clamp_count(na_cfg_reg, MAX_ACTIONS);
    assign na_last = na_eff - CW'(1);

    // Range checks
    assign st_ok  = CW'(item_reg.state_index) < ns_eff;
    assign sym_ok = CW'(item_reg.symbol_in) < nx_eff;
    assign act_ok = CW'(item_reg.action_index) < na_eff;
    assign val_ok = CW'(item_reg.table_value) < ns_eff;
    assign cs_ok  = CW'(cs_reg) < ns_eff;

    assign is_step         = (item_reg.req_type == smac_pkg::REQ_STEP);
    assign status.is_write = (item_reg.req_type == smac_pkg::REQ_WR_NEXT) ||
                             (item_reg.req_type == smac_pkg::REQ_WR_WEIGHT);
    assign status.step_ok  = is_step && sym_ok && cs_ok;

    // Table row: state times the maximum symbol count plus symbol
    assign sel_state = is_step ? 8'(cs_reg) : 8'(item_reg.state_index);
    assign row_full  = (RW+9)'(sel_state) * (RW+9)'(MAX_SYMBOLS) +
                       (RW+9)'(item_reg.symbol_in);
    assign base_full = (WAW+9)'(row_reg) * (WAW+9)'(MAX_ACTIONS);

    // Table writes
    assign ns_we    = cmd.write && (item_reg.req_type == smac_pkg::REQ_WR_NEXT) &&
                      st_ok && sym_ok && val_ok;
    assign wt_we    = cmd.write && (item_reg.req_type == smac_pkg::REQ_WR_WEIGHT) &&
                      st_ok && sym_ok && act_ok;
    assign wt_waddr = WAW'(base_full) + WAW'(item_reg.action_index);

    // Weight reads: first entry while reducing, then one ahead during the scan
    assign cnt_plus = WAW'(cnt_reg) + WAW'(1);
    assign wt_raddr = cmd.reduce ? base_reg : base_reg + cnt_plus;
    assign wt_re    = cmd.reduce || (cmd.scan && !scan_hit);

    // Threshold modulo the weight total by reciprocal multiplication
    assign prod_next = PW'(item_reg.random_value) * PW'(RECIP);
    assign quot      = prod_reg[PW-1:smac_pkg::RECIP_SHIFT];
    assign qd_full   = 25'(quot) * 25'(WEIGHT_TOTAL);
    assign p_raw     = item_reg.random_value - qd_reg;
    assign p_next    = (13'(p_raw) >= 13'(WEIGHT_TOTAL)) ? p_raw - 12'(WEIGHT_TOTAL) : p_raw;

    // Running sum against the threshold
    assign sum_next        = sum_reg + smac_pkg::SUM_W'(wt_rdata);
    assign scan_hit        = (sum_next >= smac_pkg::SUM_W'(p_reg)) ||
                             (CW'(cnt_reg) == na_last);
    assign status.scan_hit = scan_hit;

    // Next-state table
    smac_ram #(
        .WIDTH (SW),
        .DEPTH (NS_DEPTH)
    ) u_ns_ram (
        .clk   (clk),
        .we    (ns_we),
        .waddr (row_reg),
        .wdata (item_reg.table_value[SW-1:0]),
        .re    (cmd.lookup),
        .raddr (row_reg),
        .rdata (ns_rdata)
    );

    // Weight table
    smac_ram #(
        .WIDTH (smac_pkg::WEIGHT_W),
        .DEPTH (WT_DEPTH)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (item_reg.table_value),
        .re    (wt_re),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    // Configuration and current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_cfg_reg <= smac_pkg::CFG_RESET;
            nx_cfg_reg <= smac_pkg::CFG_RESET;
            na_cfg_reg <= smac_pkg::CFG_RESET;
            cs_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    smac_pkg::CFG_NUM_STATES:  ns_cfg_reg <= cfg_data;
                    smac_pkg::CFG_NUM_SYMBOLS: nx_cfg_reg <= cfg_data;
                    smac_pkg::CFG_NUM_ACTIONS: na_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.write)
                cs_reg <= '0;
            else if (cmd.scan && scan_hit)
                cs_reg <= nxt_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
            act_reg  <= '0;
        end
        if (cmd.decode)
        begin
            row_reg  <= RW'(row_full);
            prod_reg <= prod_next;
        end
        if (cmd.lookup)
        begin
            base_reg <= WAW'(base_full);
            qd_reg   <= qd_full[11:0];
        end
        if (cmd.reduce)
        begin
            p_reg   <= p_next;
            nxt_reg <= ns_rdata;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.scan)
        begin
            if (scan_hit)
                act_reg <= cnt_reg;
            else
            begin
                cnt_reg <= cnt_reg + AXW'(1);
                sum_reg <= sum_next;
            end
        end
        if (cmd.load_out)
        begin
            out_reg.action_out  <= act_ext[3:0];
            out_reg.state_after <= cs_ext[3:0];
        end
    end

    assign act_ext = (AXW+4)'(act_reg);
    assign cs_ext  = (SW+4)'(cs_reg);
    assign rsp     = out_reg;

`ifndef ASSERT_OFF
    // Reduced threshold lies below the weight total
    a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reduce |=> (13'(p_reg) < 13'(WEIGHT_TOTAL)))
        else $error("threshold not reduced");

    // Scan index stays within the actions in use
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (CW'(cnt_reg) <= na_last))
        else $error("scan ran past last action");

    // A table write returns the automaton to state zero
    a_write_home: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (cs_reg == '0))
        else $error("state not cleared by write");
`endif

endmodule

/* src/stochastic_mealy_automaton_core.sv */
// Top level of the stochastic Mealy automaton: controller, datapath and ports.
//
//  Channel  Handshake                  Payload             Direction
//  req      req_valid / req_stall      in_item_t  req      into block
//  rsp      rsp_valid / rsp_stall      out_item_t rsp      out of block
//  cfg      cfg_we                     cfg_index, cfg_data into block
//
// Table writes pass through decode, write and done before the next transaction
// is accepted. A step passes decode, lookup, reduce, scan and done; the scan
// covers 1 to num_actions weights, one per cycle set by the single read port.
// rst_n is asynchronous: state returns to 0, size registers to 16; tables are
// not cleared and hold garbage until written.
// The output register holds a result under rsp_stall while the next
// transaction is accepted and worked on; it finishes once that register frees.
module stochastic_mealy_automaton_core #(
    parameter int MAX_STATES   = smac_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS  = smac_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_ACTIONS  = smac_pkg::MAX_ACTIONS_DEF,
    parameter int WEIGHT_TOTAL = smac_pkg::WEIGHT_TOTAL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  smac_pkg::in_item_t             req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output smac_pkg::out_item_t            rsp,
    input  logic                           cfg_we,
    input  logic [smac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smac_pkg::CFG_W-1:0]     cfg_data
);

    smac_pkg::ctrl_cmd_t  cmd;
    smac_pkg::dp_status_t status;

    // Sequencer
    smac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    smac_dp #(
        .MAX_STATES   (MAX_STATES),
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .MAX_ACTIONS  (MAX_ACTIONS),
        .WEIGHT_TOTAL (WEIGHT_TOTAL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the stochastic Mealy automaton core.
module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 30;     // longest step scans 16 weights
    localparam int N_ST          = smac_pkg::MAX_STATES_DEF;
    localparam int N_SY          = smac_pkg::MAX_SYMBOLS_DEF;
    localparam int N_AC          = smac_pkg::MAX_ACTIONS_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    smac_pkg::in_item_t             req;
    logic                           rsp_valid;
    logic                           rsp_stall;
    smac_pkg::out_item_t            rsp;
    logic                           cfg_we;
    logic [smac_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [smac_pkg::CFG_W-1:0]     cfg_data;

    // Shadow copy of the automaton
    logic [smac_pkg::CFG_W-1:0] states_reg;
    logic [smac_pkg::CFG_W-1:0] symbols_reg;
    logic [smac_pkg::CFG_W-1:0] actions_reg;
    logic [3:0]       next_tbl [N_ST*N_SY];
    logic [7:0]       weight_tbl [N_ST*N_SY*N_AC];
    bit               next_known [N_ST*N_SY];
    bit               weight_known [N_ST*N_SY*N_AC];
    logic [3:0]       cur_state;

    smac_pkg::out_item_t pending_moves [$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        hold_request = 0;
    bit        calm = 1'b0;

    stochastic_mealy_automaton_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Size register value to count in use: 0 acts as 1, saturate at max
    function automatic int eff_count(logic [smac_pkg::CFG_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    // Apply one transaction to the shadow automaton, return the expected move
    function automatic smac_pkg::out_item_t mealy_step(smac_pkg::in_item_t t);
        int        ns;
        int        nx;
        int        na;
        int        slot;
        int        base;
        int        thresh;
        int        sum;
        int        act_sel;
        bit        hit;
        smac_pkg::out_item_t o;
        ns = eff_count(states_reg, N_ST);
        nx = eff_count(symbols_reg, N_SY);
        na = eff_count(actions_reg, N_AC);
        act_sel = 0;
        case (t.req_type)
            smac_pkg::REQ_WR_NEXT:
            begin
                if (t.state_index < ns && t.symbol_in < nx && t.table_value < ns)
                begin
                    slot = t.state_index * N_SY + t.symbol_in;
                    next_tbl[slot] = t.table_value[3:0];
                    next_known[slot] = 1'b1;
                end
                cur_state = '0;
            end
            smac_pkg::REQ_WR_WEIGHT:
            begin
                if (t.state_index < ns && t.symbol_in < nx && t.action_index < na)
                begin
                    slot = (t.state_index * N_SY + t.symbol_in) * N_AC + t.action_index;
                    weight_tbl[slot] = t.table_value;
                    weight_known[slot] = 1'b1;
                end
                cur_state = '0;
            end
            smac_pkg::REQ_STEP:
            begin
                if (t.symbol_in < nx && cur_state < ns)
                begin
                    thresh = t.random_value % smac_pkg::WEIGHT_TOTAL_DEF;
                    base = (cur_state * N_SY + t.symbol_in) * N_AC;
                    sum = 0;
                    hit = 1'b0;
                    act_sel = na - 1;
                    for (int i = 0; i < na && !hit; i++)
                    begin
                        sum += weight_tbl[base + i];
                        if (sum >= thresh)
                        begin
                            act_sel = i;
                            hit = 1'b1;
                        end
                    end
                    cur_state = next_tbl[cur_state * N_SY + t.symbol_in];
                end
            end
            default: ;
        endcase
        o.action_out = act_sel[3:0];
        o.state_after = cur_state;
        return o;
    endfunction

    // A step is safe when it reads no table entry that was never written
    function automatic bit step_ready(int sym);
        int ns;
        int nx;
        int na;
        int base;
        bit ok;
        ns = eff_count(states_reg, N_ST);
        nx = eff_count(symbols_reg, N_SY);
        na = eff_count(actions_reg, N_AC);
        if (sym >= nx || cur_state >= ns)
            return 1'b1;
        ok = next_known[cur_state * N_SY + sym];
        base = (cur_state * N_SY + sym) * N_AC;
        for (int a = 0; a < na; a++)
            ok = ok & weight_known[base + a];
        return ok;
    endfunction

    // Random in-range symbol that can be stepped safely, -1 if none
    function automatic int pick_step_symbol();
        int nx;
        int cands [$];
        nx = eff_count(symbols_reg, N_SY);
        for (int y = 0; y < nx; y++)
            if (step_ready(y))
                cands.push_back(y);
        if (cands.size() == 0)
            return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_weight();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return 0;
        if (r == 2)
            return 255;
        return $urandom_range(0, 40);
    endfunction

    // Threshold: half over the whole field, half near the weight sums
    function automatic int pick_threshold();
        if ($urandom_range(0, 1) == 1)
            return $urandom_range(0, 4095);
        return $urandom_range(0, eff_count(actions_reg, N_AC) * 24);
    endfunction

    function automatic smac_pkg::in_item_t make_item(logic [1:0] kind, int st, int sym,
                                                     int act, int val, int rnd);
        smac_pkg::in_item_t t;
        t.req_type = kind;
        t.state_index = 4'(st);
        t.symbol_in = 4'(sym);
        t.action_index = 4'(act);
        t.table_value = 8'(val);
        t.random_value = 12'(rnd);
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Offer one transaction, record its expected move once accepted.
    // Called and returns just after a falling edge.
    task automatic send_item(input smac_pkg::in_item_t t);
        int gap;
        req = t;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_moves.push_back(mealy_step(t));
        gap = pick_gap();
        @(negedge clk);
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic write_next(input int st, input int sym, input int val);
        send_item(make_item(smac_pkg::REQ_WR_NEXT, st, sym, $urandom_range(0, 15), val,
                            $urandom_range(0, 4095)));
    endtask

    task automatic write_weight(input int st, input int sym, input int act, input int val);
        send_item(make_item(smac_pkg::REQ_WR_WEIGHT, st, sym, act, val,
                            $urandom_range(0, 4095)));
    endtask

    task automatic take_step(input int sym, input int rnd);
        send_item(make_item(smac_pkg::REQ_STEP, $urandom_range(0, 15), sym,
                            $urandom_range(0, 15), $urandom_range(0, 255), rnd));
    endtask

    // Sender pause: all moves back, then let the block settle
    task automatic wait_idle();
        while (pending_moves.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [smac_pkg::CFG_IDX_W-1:0] idx,
                              input logic [smac_pkg::CFG_W-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            smac_pkg::CFG_NUM_STATES:  states_reg = val;
            smac_pkg::CFG_NUM_SYMBOLS: symbols_reg = val;
            smac_pkg::CFG_NUM_ACTIONS: actions_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_sizes(input logic [smac_pkg::CFG_W-1:0] ns,
                             input logic [smac_pkg::CFG_W-1:0] nx,
                             input logic [smac_pkg::CFG_W-1:0] na);
        wait_idle();
        write_size(smac_pkg::CFG_NUM_STATES, ns);
        write_size(smac_pkg::CFG_NUM_SYMBOLS, nx);
        write_size(smac_pkg::CFG_NUM_ACTIONS, na);
    endtask

    // Fill next-state and weight entries for the selected states and symbols
    task automatic program_tables(input bit [15:0] st_mask, input bit [15:0] sym_mask);
        int ns;
        int nx;
        int na;
        int dest;
        ns = eff_count(states_reg, N_ST);
        nx = eff_count(symbols_reg, N_SY);
        na = eff_count(actions_reg, N_AC);
        for (int s = 0; s < ns; s++)
            for (int y = 0; y < nx; y++)
                if (st_mask[s] && sym_mask[y])
                begin
                    do
                        dest = $urandom_range(0, ns - 1);
                    while (!st_mask[dest]);
                    write_next(s, y, dest);
                    for (int a = 0; a < na; a++)
                        write_weight(s, y, a, pick_weight());
                end
    endtask

    // Mostly well-formed steps, plus rewrites, noise and stray writes
    task automatic run_random(input int count);
        int r;
        int sym;
        int ns;
        int nx;
        int na;
        for (int i = 0; i < count; i++)
        begin
            ns = eff_count(states_reg, N_ST);
            nx = eff_count(symbols_reg, N_SY);
            na = eff_count(actions_reg, N_AC);
            r = $urandom_range(0, 99);
            sym = pick_step_symbol();
            if (r < 70 && sym >= 0)
                take_step(sym, pick_threshold());
            else if (r >= 70 && r < 76 && nx < N_SY)
                take_step($urandom_range(nx, N_SY - 1), $urandom_range(0, 4095));
            else if (r >= 76 && r < 80)
                send_item(make_item(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 255),
                                    $urandom_range(0, 4095)));
            else if (r >= 92 && r < 96)
                write_next($urandom_range(0, ns - 1), $urandom_range(0, nx - 1),
                           $urandom_range(0, ns - 1));
            else if (r >= 96)
                send_item(make_item($urandom_range(0, 1) ? smac_pkg::REQ_WR_WEIGHT
                                                         : smac_pkg::REQ_WR_NEXT,
                                    $urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 255),
                                    $urandom_range(0, 4095)));
            else
                write_weight($urandom_range(0, ns - 1), $urandom_range(0, nx - 1),
                             $urandom_range(0, na - 1), pick_weight());
        end
    endtask

    // Field extremes, every request type, threshold above the weight total
    task automatic test_table_writes();
        set_sizes(5'd31, 5'd16, 5'd0);
        write_next(0, 15, 15);
        write_next(15, 15, 0);
        write_next(15, 0, 255);          // next state beyond range: dropped
        write_weight(0, 15, 0, 255);
        write_weight(15, 15, 0, 0);
        write_weight(0, 15, 15, 7);      // action beyond range: dropped
        take_step(15, 4095);
        take_step(15, 0);
        take_step(15, 256);
        send_item(make_item(REQ_UNUSED, 15, 15, 15, 255, 4095));
        write_next(0, 0, 0);
        write_weight(0, 0, 0, 0);
        take_step(0, 1);
    endtask

    // Dropped writes, symbol out of range, state stranded by a smaller size
    task automatic test_out_of_range();
        take_step(15, 4095);
        set_sizes(5'd8, 5'd4, 5'd2);
        take_step(15, 100);
        take_step(1, 100);
        write_next(8, 0, 0);
        write_next(0, 4, 0);
        write_next(0, 0, 8);
        write_weight(8, 0, 0, 1);
        write_weight(0, 4, 0, 1);
        write_weight(0, 0, 2, 5);
        write_weight(0, 0, 1, 200);
        take_step(0, 100);
        take_step(0, 4095);
    endtask

    task automatic test_small_automaton();
        set_sizes(5'd4, 5'd4, 5'd4);
        program_tables(16'h000F, 16'h000F);
        run_random(220);
    endtask

    // Receiver holds off while the sender keeps pushing, then a full drain
    task automatic test_receiver_hold();
        calm = 1'b1;
        hold_request = 400;
        run_random(80);
        wait_idle();
        calm = 1'b0;
        run_random(40);
    endtask

    task automatic test_full_size();
        set_sizes(5'd16, 5'd16, 5'd16);
        program_tables(16'h8081, 16'h8001);
        run_random(200);
    endtask

    // One state, one symbol (from 0), saturated actions; no idling here
    task automatic test_single_state();
        set_sizes(5'd1, 5'd0, 5'd31);
        calm = 1'b1;
        program_tables(16'h0001, 16'h0001);
        run_random(120);
        calm = 1'b0;
    endtask

    task automatic test_mixed_sizes();
        set_sizes(5'd8, 5'd6, 5'd3);
        program_tables(16'h00FF, 16'h0007);
        run_random(200);
    endtask

    // Receiver: random stall bursts, plus long holds on request
    initial
    begin
        int left;
        int r;
        left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                left = hold_request;
                hold_request = 0;
            end
            if (left == 0 && !calm)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    left = $urandom_range(1, 3);
                else if (r < 14)
                    left = $urandom_range(10, 30);
            end
            if (left > 0)
            begin
                rsp_stall = 1'b1;
                left--;
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        smac_pkg::out_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_moves.size() == 0)
                report_mismatch("unexpected transaction", {rsp.action_out, rsp.state_after},
                                8'h00);
            else
            begin
                want = pending_moves.pop_front();
                if (rsp.action_out !== want.action_out)
                    report_mismatch("action_out", rsp.action_out, want.action_out);
                if (rsp.state_after !== want.state_after)
                    report_mismatch("state_after", rsp.state_after, want.state_after);
            end
        end
    end

    // Test sequence
    initial
    begin
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        states_reg = smac_pkg::CFG_RESET;
        symbols_reg = smac_pkg::CFG_RESET;
        actions_reg = smac_pkg::CFG_RESET;
        cur_state = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_table_writes();
        test_out_of_range();
        test_small_automaton();
        test_receiver_hold();
        test_full_size();
        test_single_state();
        test_mixed_sizes();

        wait_idle();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* filelist.f */
src/smac_pkg.sv
src/smac_ram.sv
src/smac_ctrl.sv
src/smac_dp.sv
src/stochastic_mealy_automaton_core.sv
verif/tb_top.sv
